// ===== hdl/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types, codes and constants of the piecewise time dilation converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

  localparam int SEC_W   = 34;
  localparam int NSEC_W  = 30;
  localparam int RATE_W  = 32;
  localparam int NS_W    = 64;
  localparam int NUM_W   = 80;
  localparam int QUO_W   = 64;

  localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [NSEC_W-1:0] NSEC_MAX   = 30'd999999999;
  localparam logic [SEC_W-1:0]  SEC_MAX    = 34'h3_FFFF_FFFF;
  localparam logic [NS_W-1:0]   NS_CAP     = 64'd17179869183999999999;

  // floor(2^61 / 10^9): applied to a nanosecond count shifted right by 29 it
  // estimates whole seconds at most three below the true quotient.
  localparam logic [31:0]       RCP_1E9    = 32'd2305843009;

  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_TIME   = 2'd1;
  localparam logic [1:0] FN_SLEEP  = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [1:0] ST_CONV    = 2'd0;
  localparam logic [1:0] ST_BEFORE  = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [NSEC_W-1:0] nsec;
    logic [RATE_W-1:0] rate;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [RATE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quo;
  } div_rsp_t;

  function automatic logic [NS_W-1:0] sat_add(input logic [NS_W-1:0] a,
                                               input logic [NS_W-1:0] b);
    logic [NS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[NS_W] ? {NS_W{1'b1}} : s[NS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tdc_ram.sv =====
// ----------------------------------------------------------------------------
// tdc_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tdc_div.sv =====
// ----------------------------------------------------------------------------
// tdc_div
// Restoring divider, one quotient bit per cycle, 80-bit numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tdc_pkg::div_req_t req,
  output tdc_pkg::div_rsp_t      rsp
);

  logic                           run;
  logic [6:0]                     cnt;
  logic [tdc_pkg::NUM_W-1:0]      num_sh;
  logic [tdc_pkg::RATE_W-1:0]     den_q;
  logic [tdc_pkg::RATE_W-1:0]     rem;
  logic [tdc_pkg::QUO_W-1:0]      quo;
  logic                           ovf;
  logic                           done;
  logic [tdc_pkg::RATE_W:0]       trial;
  logic                           take;

  assign trial = {rem, num_sh[tdc_pkg::NUM_W-1]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (req.start) begin
      run    <= 1'b1;
      cnt    <= 7'(tdc_pkg::NUM_W - 1);
      num_sh <= req.num;
      den_q  <= (req.den == '0) ? tdc_pkg::RATE_W'(1) : req.den;
      rem    <= '0;
      quo    <= '0;
      ovf    <= 1'b0;
    end else if (run) begin
      num_sh <= num_sh << 1;
      rem    <= take ? tdc_pkg::RATE_W'(trial - {1'b0, den_q}) : trial[tdc_pkg::RATE_W-1:0];
      quo    <= {quo[tdc_pkg::QUO_W-2:0], take};
      // A quotient bit above bit 63 means the result does not fit.
      if (take && (cnt >= 7'(tdc_pkg::QUO_W))) begin
        ovf <= 1'b1;
      end
      if (cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt - 7'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = ovf ? {tdc_pkg::QUO_W{1'b1}} : quo;

endmodule

`default_nettype wire

// ===== hdl/piecewise_time_dilation_converter.sv =====
// ----------------------------------------------------------------------------
// piecewise_time_dilation_converter
// Maps real time to virtual time through a table of dilated time segments.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on out_sec, out_nsec and status for exactly one cycle with done
// high, and the receiver cannot stall it. A table write (func 0) and any
// item that needs no table walk return in the cycle after acceptance. A
// time conversion (func 1) turns its real time into nanoseconds and fetches
// the first segment, then runs one division for every segment it crosses,
// and ends with a split of the sum into seconds and nanoseconds. A sleep
// conversion (func 2) first scans the start seconds of the segments and
// then runs one division for every segment the sleep overlaps. The work is
// paced by the bit-serial divider, which yields one quotient bit a cycle
// over an 80-bit numerator, and by the single read port of the segment
// table. The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_time_dilation_converter #(
  parameter int MAX_SEGMENTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_data,
  input  wire logic [1:0]  func,
  input  wire logic [2:0]  entry_index,
  input  wire logic [33:0] time_sec,
  input  wire logic [29:0] time_nsec,
  input  wire logic [31:0] rate,
  input  wire logic [31:0] sleep_sec,
  output logic      [33:0] out_sec,
  output logic      [29:0] out_nsec,
  output logic      [1:0]  status
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  // What the entry being fetched is wanted for.
  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_NEXT  = 3'd1;
  localparam logic [2:0] PH_SCAN  = 3'd2;
  localparam logic [2:0] PH_CUR   = 3'd3;
  localparam logic [2:0] PH_NEXTS = 3'd4;

  typedef enum logic [17:0] {
    S_IDLE   = 18'b00_0000_0000_0000_0001,
    S_RMUL   = 18'b00_0000_0000_0000_0010,
    S_RADD   = 18'b00_0000_0000_0000_0100,
    S_FETCH  = 18'b00_0000_0000_0000_1000,
    S_EMUL   = 18'b00_0000_0000_0001_0000,
    S_EADD   = 18'b00_0000_0000_0010_0000,
    S_EUSE   = 18'b00_0000_0000_0100_0000,
    S_LOOP1  = 18'b00_0000_0000_1000_0000,
    S_SLICE  = 18'b00_0000_0001_0000_0000,
    S_DIVW   = 18'b00_0000_0010_0000_0000,
    S_FIN1   = 18'b00_0000_0100_0000_0000,
    S_CAP    = 18'b00_0000_1000_0000_0000,
    S_QMUL   = 18'b00_0001_0000_0000_0000,
    S_QSUB   = 18'b00_0010_0000_0000_0000,
    S_QFIX   = 18'b00_0100_0000_0000_0000,
    S_P2INIT = 18'b00_1000_0000_0000_0000,
    S_LOOP2  = 18'b01_0000_0000_0000_0000,
    S_FIN2   = 18'b10_0000_0000_0000_0000
  } state_t;

  state_t state;

  logic [3:0]  segment_count;
  logic [3:0]  n_act;
  logic        accept;
  logic [29:0] nsec_in;

  // Latched item and walk state.
  logic [1:0]  func_q;
  logic [33:0] tsec_q;
  logic [29:0] tnsec_q;
  logic [34:0] stop_q;
  logic [3:0]  n_q;
  logic [3:0]  i;
  logic [3:0]  first;
  logic [3:0]  last;
  logic [2:0]  phase;
  logic [63:0] r_ns;
  logic [63:0] s0;
  logic [63:0] c_ns;
  logic [63:0] nx_ns;
  logic [31:0] crate;
  logic [31:0] nrate;
  logic [63:0] total;
  logic [63:0] hi_q;
  logic [63:0] lo_q;
  logic [33:0] q_sec;

  // Table fetch path.
  logic [AW-1:0]        rd_addr;
  logic [tdc_pkg::ENT_W-1:0] rd_data;
  tdc_pkg::entry_t      ent_rd;
  tdc_pkg::entry_t      ent;
  logic [63:0]          prod;
  logic [63:0]          ent_ns;
  logic [33:0]          mul_a;
  logic [63:0]          mul_p;
  logic [66:0]          rcp_p;

  logic                 ram_we;
  tdc_pkg::entry_t      ram_wdata;

  tdc_pkg::div_req_t    dreq;
  tdc_pkg::div_rsp_t    drsp;

  logic [4:0]  i_inc;
  logic        has_next;
  logic [63:0] diff;
  logic [47:0] whole;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign nsec_in = (time_nsec > tdc_pkg::NSEC_MAX) ? tdc_pkg::NSEC_MAX : time_nsec;
  assign n_act   = (32'(segment_count) > MAX_SEGMENTS) ? 4'(MAX_SEGMENTS) : segment_count;

  assign i_inc    = {1'b0, i} + 5'd1;
  assign has_next = i_inc < {1'b0, n_q};

  // The table is only written from idle and only read while a walk runs,
  // so a read and a write never meet on the same entry.
  assign ram_we         = accept && (func == tdc_pkg::FN_WRITE) &&
                          (32'(entry_index) < MAX_SEGMENTS);
  assign ram_wdata.sec  = time_sec;
  assign ram_wdata.nsec = nsec_in;
  assign ram_wdata.rate = rate;

  tdc_ram #(
    .WIDTH(tdc_pkg::ENT_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(entry_index)),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign ent_rd = tdc_pkg::entry_t'(rd_data);

  tdc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(dreq),
    .rsp(drsp)
  );

  // One shared multiplier turns seconds into nanoseconds: for the real time
  // of the item, for the start of a fetched segment, or for the estimated
  // seconds of the final split.
  assign mul_a = (state == S_RMUL) ? tsec_q :
                 (state == S_QMUL) ? q_sec  : ent_rd.sec;
  assign mul_p = {30'd0, mul_a} * {34'd0, tdc_pkg::NS_PER_SEC};

  // Reciprocal estimate of whole seconds in the virtual nanosecond count.
  assign rcp_p = {32'd0, hi_q[63:29]} * {35'd0, tdc_pkg::RCP_1E9};

  assign diff  = (hi_q > lo_q) ? (hi_q - lo_q) : 64'd0;
  assign whole = total[63:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
    end else if (cfg_we) begin
      segment_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    done       <= 1'b0;
    dreq.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_q  <= func;
            tsec_q  <= time_sec;
            tnsec_q <= nsec_in;
            stop_q  <= {1'b0, time_sec} + 35'(sleep_sec);
            n_q     <= n_act;
            rd_addr <= '0;
            i       <= '0;
            total   <= '0;
            first   <= '0;
            last    <= n_act;
            case (func)
              tdc_pkg::FN_WRITE: begin
                out_sec  <= '0;
                out_nsec <= '0;
                status   <= tdc_pkg::ST_WRITTEN;
                done     <= 1'b1;
              end
              tdc_pkg::FN_TIME: begin
                if (n_act == '0) begin
                  out_sec  <= time_sec;
                  out_nsec <= nsec_in;
                  status   <= tdc_pkg::ST_NONE;
                  done     <= 1'b1;
                end else begin
                  phase <= PH_FIRST;
                  state <= S_RMUL;
                end
              end
              tdc_pkg::FN_SLEEP: begin
                if (n_act == '0) begin
                  out_sec  <= 34'(sleep_sec);
                  out_nsec <= '0;
                  status   <= tdc_pkg::ST_NONE;
                  done     <= 1'b1;
                end else begin
                  phase <= PH_SCAN;
                  state <= S_FETCH;
                end
              end
              default: begin
                out_sec  <= '0;
                out_nsec <= '0;
                status   <= tdc_pkg::ST_NONE;
                done     <= 1'b1;
              end
            endcase
          end
        end
        S_RMUL: begin
          prod  <= mul_p;
          state <= S_RADD;
        end
        S_RADD: begin
          r_ns  <= prod + 64'(tnsec_q);
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_EMUL;
        end
        S_EMUL: begin
          prod  <= mul_p;
          ent   <= ent_rd;
          state <= S_EADD;
        end
        S_EADD: begin
          ent_ns <= prod + 64'(ent.nsec);
          state  <= S_EUSE;
        end
        S_EUSE: begin
          case (phase)
            PH_FIRST: begin
              s0    <= ent_ns;
              c_ns  <= ent_ns;
              crate <= ent.rate;
              if (ent_ns > r_ns) begin
                // Real time lies before the first segment: pass it through.
                out_sec  <= tsec_q;
                out_nsec <= tnsec_q;
                status   <= tdc_pkg::ST_BEFORE;
                done     <= 1'b1;
                state    <= S_IDLE;
              end else begin
                state <= S_LOOP1;
              end
            end
            PH_NEXT: begin
              nx_ns <= ent_ns;
              nrate <= ent.rate;
              hi_q  <= (ent_ns <= r_ns) ? ent_ns : r_ns;
              lo_q  <= c_ns;
              state <= S_SLICE;
            end
            PH_SCAN: begin
              if (tsec_q >= ent.sec) begin
                first <= i;
              end
              if (stop_q <= {1'b0, ent.sec}) begin
                last  <= i;
                state <= S_P2INIT;
              end else if (!has_next) begin
                state <= S_P2INIT;
              end else begin
                i       <= i_inc[3:0];
                rd_addr <= AW'(i_inc);
                state   <= S_FETCH;
              end
            end
            PH_CUR: begin
              lo_q  <= 64'((tsec_q >= ent.sec) ? tsec_q : ent.sec);
              crate <= ent.rate;
              if (has_next) begin
                rd_addr <= AW'(i_inc);
                phase   <= PH_NEXTS;
                state   <= S_FETCH;
              end else begin
                hi_q  <= 64'(stop_q);
                state <= S_SLICE;
              end
            end
            PH_NEXTS: begin
              hi_q  <= (stop_q > {1'b0, ent.sec}) ? 64'(ent.sec) : 64'(stop_q);
              state <= S_SLICE;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_LOOP1: begin
          if ((i == n_q) || (c_ns >= r_ns)) begin
            state <= S_FIN1;
          end else if (has_next) begin
            rd_addr <= AW'(i_inc);
            phase   <= PH_NEXT;
            state   <= S_FETCH;
          end else begin
            hi_q  <= r_ns;
            lo_q  <= c_ns;
            state <= S_SLICE;
          end
        end
        S_SLICE: begin
          // Time slices carry 16 fraction bits of the rate; sleep slices
          // keep 16 more so that the sum stays a Q.16 seconds count.
          dreq.start <= 1'b1;
          dreq.den   <= crate;
          dreq.num   <= (func_q == tdc_pkg::FN_TIME) ? {diff, 16'd0} : (80'(diff) << 32);
          state      <= S_DIVW;
        end
        S_DIVW: begin
          if (drsp.done) begin
            total <= tdc_pkg::sat_add(total, drsp.quo);
            i     <= i_inc[3:0];
            if (func_q == tdc_pkg::FN_TIME) begin
              c_ns  <= nx_ns;
              crate <= nrate;
              state <= S_LOOP1;
            end else begin
              state <= S_LOOP2;
            end
          end
        end
        S_FIN1: begin
          hi_q  <= tdc_pkg::sat_add(s0, total);
          state <= S_CAP;
        end
        S_CAP: begin
          if (hi_q > tdc_pkg::NS_CAP) begin
            out_sec  <= tdc_pkg::SEC_MAX;
            out_nsec <= tdc_pkg::NSEC_MAX;
            status   <= tdc_pkg::ST_CONV;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            // The estimate is never above the true seconds count and at most
            // three below it.
            q_sec <= 34'(rcp_p[66:32]);
            state <= S_QMUL;
          end
        end
        S_QMUL: begin
          prod  <= mul_p;
          state <= S_QSUB;
        end
        S_QSUB: begin
          lo_q  <= hi_q - prod;
          state <= S_QFIX;
        end
        S_QFIX: begin
          // Step the estimate up until the leftover is below one second.
          if (lo_q >= 64'(tdc_pkg::NS_PER_SEC)) begin
            lo_q  <= lo_q - 64'(tdc_pkg::NS_PER_SEC);
            q_sec <= q_sec + 34'd1;
          end else begin
            out_sec  <= q_sec;
            out_nsec <= lo_q[29:0];
            status   <= tdc_pkg::ST_CONV;
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_P2INIT: begin
          i     <= first;
          state <= S_LOOP2;
        end
        S_LOOP2: begin
          if (i >= last) begin
            state <= S_FIN2;
          end else begin
            rd_addr <= AW'(i);
            phase   <= PH_CUR;
            state   <= S_FETCH;
          end
        end
        S_FIN2: begin
          out_sec  <= (|whole[47:34]) ? tdc_pkg::SEC_MAX : whole[33:0];
          out_nsec <= '0;
          status   <= tdc_pkg::ST_CONV;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tdc_checker.sv =====
// ----------------------------------------------------------------------------
// tdc_checker
// Port-level checks of the converter's command and result timing and of its result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [33:0] out_sec,
  input wire logic [29:0] out_nsec,
  input wire logic [1:0]  status
);

  // A result always leaves the block free for the next item.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // An accepted item either works on or answers at once.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item lost");

  // A table write answers with zero time fields.
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == tdc_pkg::ST_WRITTEN)) |-> ((out_sec == '0) && (out_nsec == '0)))
    else $error("write result carries time");

  // Nanoseconds stay below one second.
  a_nsec_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_nsec <= tdc_pkg::NSEC_MAX))
    else $error("nanoseconds out of range");

endmodule

bind piecewise_time_dilation_converter tdc_checker u_tdc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .out_sec (out_sec),
  .out_nsec(out_nsec),
  .status  (status)
);

`default_nettype wire
